// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box and round functions for the AES-128 round pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

   localparam int NumRounds = 10;
   localparam int StageBits = 4;

   typedef logic [127:0] block_type;

   // Configuration register indexes
   localparam logic CsrKeyHigh = 1'b0;
   localparam logic CsrKeyLow  = 1'b1;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r;
      unique case (x)
         8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
         8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
         8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
         8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
         8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
         8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
         8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
         8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
         8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
         8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
         8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
         8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
         8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
         8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
         8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
         8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
         8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
         8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
         8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
         8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
         8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
         8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
         8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
         8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
         8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
         8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
         8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
         8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
         8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
         8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
         8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
         8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
         8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
         8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
         8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
         8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
         8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
         8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
         8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
         8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
         8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
         8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
         8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
         8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
         8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
         8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
         8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
         8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
         8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
         8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
         8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
         8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
         8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
         8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
         8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
         8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
         8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
         8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
         8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
         8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
         8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
         8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
         8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
         8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Byte i of a block sits at bits 127-8i -: 8
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[127 - 8 * i -: 8];
   endfunction

   function automatic logic [7:0] gf_dbl(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Round constant for round r (1..10)
   function automatic logic [7:0] rcon(input logic [StageBits-1:0] r);
      logic [7:0] c;
      unique case (r)
         4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
         4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
         4'd9: c = 8'h1b; 4'd10: c = 8'h36;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Next round key from the previous one
   function automatic block_type next_key(input block_type k, input logic [StageBits-1:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // SubBytes + ShiftRows, optionally MixColumns
   function automatic block_type round_fn(input block_type s, input logic mix);
      block_type t, m;
      logic [7:0] a, b, d, e, all;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = sbox(get_byte(s, 4 * ((c + r) % 4) + r));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a = get_byte(t, 4 * c);
         b = get_byte(t, 4 * c + 1);
         d = get_byte(t, 4 * c + 2);
         e = get_byte(t, 4 * c + 3);
         all = a ^ b ^ d ^ e;
         m[127 - 32 * c -: 8]       = a ^ all ^ gf_dbl(a ^ b);
         m[127 - 32 * c - 8 -: 8]   = b ^ all ^ gf_dbl(b ^ d);
         m[127 - 32 * c - 16 -: 8]  = d ^ all ^ gf_dbl(d ^ e);
         m[127 - 32 * c - 24 -: 8]  = e ^ all ^ gf_dbl(e ^ a);
      end
      return mix ? m : t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round stage
// One pipeline stage: a cipher round plus the matching key expansion step.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    advance,
   input  wire [aes_pkg::StageBits-1:0] round_num,
   input  wire                    in_valid,
   input  aes_pkg::block_type     in_state,
   input  aes_pkg::block_type     in_key,
   output logic                   out_valid,
   output aes_pkg::block_type     out_state,
   output aes_pkg::block_type     out_key
);
   import aes_pkg::*;

   logic      valid_ff;
   block_type state_ff, state_in;
   block_type key_ff, key_in;

   // round key derived here, used here and passed on
   always_comb begin
      key_in   = next_key(in_key, round_num);
      state_in = round_fn(in_state, round_num != StageBits'(NumRounds)) ^ key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
         key_ff   <= key_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_key   = key_ff;

endmodule

`default_nettype wire

// ===== rtl/aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Fully unrolled AES-128 pipeline, one block per clock unless stalled.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req_    | in        | req_valid/stall  | plaintext_high, plaintext_low
//  rsp_    | out       | rsp_valid/stall  | ciphertext_high, ciphertext_low
//  csr_    | in        | csr_valid/ready  | index, wdata (key_high, key_low)
//
//  The pipeline has one AddRoundKey stage and ten round stages, with key
//  expansion alongside each round. A new block enters every cycle unless
//  req_stall is high. Reset clears all valid bits and both key registers.
//  A stall on rsp_ holds the whole pipeline only while the output stage
//  is full; req_stall is raised only then.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_encrypt (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_plaintext_high,
   input  wire  [63:0] req_plaintext_low,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_ciphertext_high,
   output logic [63:0] rsp_ciphertext_low,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [63:0] csr_wdata
);
   import aes_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   logic        advance;
   logic        v0_ff;
   block_type   s0_ff, k0_ff;
   logic        v [NumRounds+1];
   block_type   s [NumRounds+1];
   block_type   k [NumRounds+1];

   // Whole pipeline moves unless the last stage holds an untaken result
   assign advance   = !(v[NumRounds] && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index[0])
            CsrKeyHigh: key_high_ff <= csr_wdata;
            CsrKeyLow:  key_low_ff  <= csr_wdata;
            default:    key_high_ff <= key_high_ff;
         endcase
      end
   end

   // Initial AddRoundKey stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff <= {req_plaintext_high, req_plaintext_low} ^ {key_high_ff, key_low_ff};
         k0_ff <= {key_high_ff, key_low_ff};
      end
   end

   assign v[0] = v0_ff;
   assign s[0] = s0_ff;
   assign k[0] = k0_ff;

   // Ten round stages
   for (genvar r = 1; r <= NumRounds; r++) begin : g_round
      aes_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .round_num (StageBits'(r)),
         .in_valid  (v[r-1]),
         .in_state  (s[r-1]),
         .in_key    (k[r-1]),
         .out_valid (v[r]),
         .out_state (s[r]),
         .out_key   (k[r])
      );
   end

   assign rsp_valid           = v[NumRounds];
   assign rsp_ciphertext_high = s[NumRounds][127:64];
   assign rsp_ciphertext_low  = s[NumRounds][63:0];

endmodule

`default_nettype wire

// ===== rtl/aes_checker.sv =====
// ----------------------------------------------------------------------------
// AES port checker
// Port-level checks on the block encrypt top level, bound in below.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [63:0] rsp_ciphertext_high,
   input wire [63:0] rsp_ciphertext_low
);

   // A stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable(rsp_ciphertext_high) && $stable(rsp_ciphertext_low))
      else $error("stalled result changed");

   // Input is stalled only while the output is held
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // No results straight out of reset
   a_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // An accepted transfer shows up at the output when the output is not stalled in between
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall [*10] |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_ciphertext_high (rsp_ciphertext_high),
   .rsp_ciphertext_low  (rsp_ciphertext_low)
);

`default_nettype wire

// ===== tb/sv/aes128_block_encrypt_checker.sv =====
// ----------------------------------------------------------------------------
// AES-128 block encrypt checker
// Watches the key, plaintext and ciphertext channels, computes the expected
// ciphertext of every accepted block under the key held at that moment, and
// compares each ciphertext transfer in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_encrypt_checker
   import aes_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire  [63:0] req_plaintext_high,
   input  wire  [63:0] req_plaintext_low,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [63:0] rsp_ciphertext_high,
   input  wire  [63:0] rsp_ciphertext_low,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [63:0] csr_wdata,
   output int          error_count,
   output int          blocks_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]   sub_byte [256];
   logic [63:0]  cur_key_high = '0;
   logic [63:0]  cur_key_low  = '0;
   block_type    expected_cipher [$];

   initial error_count = 0;
   initial blocks_in_flight = 0;

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = xtime(a);
      end
      return p;
   endfunction

   // S-box from the field inverse plus the affine map
   initial begin
      logic [7:0] inv, x;
      for (int v = 0; v < 256; v++) begin
         x = v[7:0];
         inv = '0;
         for (int y = 1; y < 256; y++) begin
            if (x != 0 && gf_mul(x, y[7:0]) == 8'h01) inv = y[7:0];
         end
         sub_byte[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                       ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   end

   // Full AES-128 encryption, round keys rolled forward per round
   function automatic block_type encrypt_block(input block_type pt, input block_type key);
      logic [7:0] st [16];
      logic [7:0] sh [16];
      logic [7:0] rk [16];
      logic [7:0] rc, a, b, d, e, all;
      block_type  ct;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         st[i] = pt[127 - 8 * i -: 8] ^ key[127 - 8 * i -: 8];
         rk[i] = key[127 - 8 * i -: 8];
      end
      for (int rnd = 1; rnd <= 10; rnd++) begin
         // sub bytes and shift rows
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               sh[4 * c + r] = sub_byte[st[4 * ((c + r) % 4) + r]];
         // mix columns, all rounds but the last
         for (int c = 0; c < 4; c++) begin
            a = sh[4 * c]; b = sh[4 * c + 1]; d = sh[4 * c + 2]; e = sh[4 * c + 3];
            all = a ^ b ^ d ^ e;
            if (rnd < 10) begin
               st[4 * c]     = a ^ all ^ xtime(a ^ b);
               st[4 * c + 1] = b ^ all ^ xtime(b ^ d);
               st[4 * c + 2] = d ^ all ^ xtime(d ^ e);
               st[4 * c + 3] = e ^ all ^ xtime(e ^ a);
            end else begin
               st[4 * c] = a; st[4 * c + 1] = b; st[4 * c + 2] = d; st[4 * c + 3] = e;
            end
         end
         // next round key
         rk[0] ^= sub_byte[rk[13]] ^ rc;
         rk[1] ^= sub_byte[rk[14]];
         rk[2] ^= sub_byte[rk[15]];
         rk[3] ^= sub_byte[rk[12]];
         for (int j = 4; j < 16; j++) rk[j] ^= rk[j - 4];
         rc = xtime(rc);
         for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      end
      for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = st[i];
      return ct;
   endfunction

   // Track key writes, queue predictions, compare results
   always @(posedge clock) begin
      block_type want;
      if (reset) begin
         cur_key_high <= '0;
         cur_key_low  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrKeyHigh) cur_key_high <= csr_wdata;
            else if (csr_index == CsrKeyLow) cur_key_low <= csr_wdata;
         end
         if (req_valid && !req_stall)
            expected_cipher.push_back(encrypt_block({req_plaintext_high, req_plaintext_low},
                                                    {cur_key_high, cur_key_low}));
         if (rsp_valid && !rsp_stall) begin
            if (expected_cipher.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: unexpected ciphertext %h_%h", rsp_ciphertext_high,
                           rsp_ciphertext_low);
            end else begin
               want = expected_cipher.pop_front();
               if (rsp_ciphertext_high !== want[127:64] ||
                   rsp_ciphertext_low !== want[63:0]) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: ciphertext exp %h_%h got %h_%h", want[127:64],
                              want[63:0], rsp_ciphertext_high, rsp_ciphertext_low);
               end
            end
         end
      end
      blocks_in_flight = expected_cipher.size();
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Drives directed and random plaintext blocks under several keys, with random
// sender gaps and receiver stalls, a long output hold-off and a full drain.
// The checker module predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_aes128_block_encrypt;
   import aes_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LatencyCycles = 11;
   localparam int HoldCycles    = 200;
   localparam int CycleLimit    = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_plaintext_high = '0;
   logic [63:0] req_plaintext_low  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_ciphertext_high;
   logic [63:0] rsp_ciphertext_low;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CsrKeyHigh;
   logic [63:0] csr_wdata = '0;

   int error_count;
   int blocks_in_flight;
   int gap_pct   = 0;
   int stall_pct = 0;
   bit hold_request = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   aes128_block_encrypt u_dut (.*);

   aes128_block_encrypt_checker u_checker (.*);

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: random stalls, or a counted hold-off on request
   initial begin
      forever begin
         if (hold_request) begin
            hold_request = 0;
            for (int n = 0; n < HoldCycles; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
            @(posedge clock);
         end
      end
   end

   task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_plaintext_high <= hi;
      req_plaintext_low  <= lo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender stops until every ciphertext is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (blocks_in_flight != 0) @(posedge clock);
      repeat (LatencyCycles + 2) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_blocks(input int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: send_block('0, rand64());
            1: send_block('1, rand64());
            2: send_block(rand64(), 64'h1 << $urandom_range(63));
            default: send_block(rand64(), rand64());
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset key (all zero), then the standard example key
      send_block('0, '0);
      send_block('1, '1);
      drain();
      write_key(CsrKeyHigh, 64'h0001020304050607);
      write_key(CsrKeyLow,  64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      send_block(64'h8000000000000000, 64'h0000000000000001);
      for (int b = 0; b < 8; b++) send_block(64'h1 << (8 * b), 64'h80 << (8 * b));
      drain();
      // Key change between blocks: all-ones key, then only the low half
      write_key(CsrKeyHigh, '1);
      write_key(CsrKeyLow,  '1);
      send_block('0, '0);
      send_block('1, '1);
      drain();
      write_key(CsrKeyLow, '0);
      send_block('0, '0);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      drain();

      // Random phases, each with a fresh key
      for (int ph = 0; ph < 4; ph++) begin
         gap_pct   = (ph == 1 || ph == 3) ? ((ph == 1) ? 87 : 20) : 0;
         stall_pct = (ph == 2) ? 87 : ((ph == 3) ? 20 : 0);
         write_key(CsrKeyHigh, (ph == 0) ? 64'h2b7e151628aed2a6 : rand64());
         write_key(CsrKeyLow,  (ph == 0) ? 64'habf7158809cf4f3c : rand64());
         random_blocks(200);
         if (ph == 0) begin
            // long output hold-off while blocks keep coming
            hold_request = 1;
            random_blocks(60);
         end
         drain();
         random_blocks(250);
         drain();
      end

      gap_pct = 0;
      stall_pct = 0;
      drain();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/aes_pkg.sv
rtl/aes_round.sv
rtl/aes128_block_encrypt.sv
rtl/aes_checker.sv
tb/sv/aes128_block_encrypt_checker.sv
tb/sv/tb_aes128_block_encrypt.sv
